### src/sactc_pkg.sv
// Shared types and constants for the set-associative cache tag controller.
// No dependencies.
package sactc_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;
  localparam logic [1:0] CMD_OTHER = 2'd3;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;

  localparam int CNT_W = 32;
  localparam int NUM_CNT = 7;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic       hit;
    logic       miss;
    logic       wb;
    logic [1:0] command;
  } event_t;

endpackage

### src/sactc_counters.sv
// Saturating access counters for the cache tag controller.
// Depends on sactc_pkg.
module sactc_counters (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         bump,
  input  sactc_pkg::event_t            ev,
  output sactc_pkg::cnt_t [6:0]        counts
);
  import sactc_pkg::*;

  cnt_t [NUM_CNT-1:0] cnt;
  logic [NUM_CNT-1:0] inc;

  always_comb begin
    inc = '0;
    if (ev.command != CMD_OTHER) begin
      inc[{ev.command, 1'b0}] = 1'b1;
      if (ev.miss) inc[{ev.command, 1'b1}] = 1'b1;
    end
    inc[6] = ev.wb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (bump) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (inc[i] && cnt[i] != '1) cnt[i] <= cnt[i] + 1'b1;
      end
    end
  end

  assign counts = cnt;
endmodule

### src/set_assoc_cache_lru_tag_controller.sv
// Set-associative write-back cache tag controller with true LRU.
// On acceptance the set row is read into a register; the result is registered from the lookup state.
// No new item is taken until the last has written its set back, nor while a result is held by out_stall.
// Reset: clearing pass sweeps one set a cycle over all SETS sets, no item taken.
// Counters and registers reset to zero and defaults at once.
module set_assoc_cache_lru_tag_controller #(
  parameter int SETS = 256,
  parameter int WAYS = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        writeback,
  output logic [2:0]  way_used,
  output logic [7:0]  set_used,
  output logic [31:0] load_total,
  output logic [31:0] load_miss_total,
  output logic [31:0] store_total,
  output logic [31:0] store_miss_total,
  output logic [31:0] fetch_total,
  output logic [31:0] fetch_miss_total,
  output logic [31:0] writeback_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import sactc_pkg::*;

  localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MAXI = $clog2(SETS + 1) - 1;
  localparam int MAXW = $clog2(WAYS + 1) - 1;
  localparam int TW = ADDR_BITS;

  typedef struct packed {
    logic          valid;
    logic          dirty;
    logic [TW-1:0] tag;
    logic [WB-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam logic [1:0] ST_CLR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  row_t mem [SETS];
  row_t rd_row, wr_row;
  logic [1:0] state;
  logic [SB:0] clr_cnt;
  logic [3:0] ob_reg, ib_reg;
  logic [1:0] wl_reg;
  logic [1:0] cmd_q;
  logic [TW-1:0] tag_q;
  logic [SB-1:0] set_q;
  logic [7:0] set_out;

  logic [3:0] ob, ib;
  logic [1:0] wl;
  logic [ADDR_BITS-1:0] a;
  logic [SB-1:0] set_c;
  logic [TW-1:0] tag_c;
  logic [WAYS:0] nways;

  logic f_hit, f_inv, wb_c;
  logic [WB-1:0] hw, iw, vw, way_c, r_sel;
  logic take, fin;
  event_t ev;
  cnt_t [6:0] counts;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign take = in_valid && !in_stall;
  assign fin = state == ST_LOOK;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_reg <= 4'd4;
      ib_reg <= 4'd8;
      wl_reg <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET: ob_reg <= cfg_data;
        REG_INDEX:  ib_reg <= cfg_data;
        REG_WAYS:   wl_reg <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ob = ob_reg < 4'd4 ? 4'd4 : (ob_reg > 4'd8 ? 4'd8 : ob_reg);
    ib = (int'(ib_reg) > MAXI) ? 4'(MAXI) : ib_reg;
    wl = (int'(wl_reg) > MAXW) ? 2'(MAXW) : wl_reg;
    nways = (WAYS+1)'(1) << wl;
    a = ADDR_BITS'(address);
    set_c = SB'((a >> ob) & ((ADDR_BITS'(1) << ib) - 1'b1));
    tag_c = TW'(a >> ({1'b0, ob} + {1'b0, ib}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SB+1)'(SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (take) state <= ST_LOOK;
        ST_LOOK: state <= ST_IDLE;
        default: state <= ST_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q <= command;
      tag_q <= tag_c;
      set_q <= set_c;
      set_out <= 8'(set_c);
    end
  end

  always_comb begin
    f_hit = 1'b0; f_inv = 1'b0;
    hw = '0; iw = '0; vw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w < int'(nways)) begin
        if (rd_row[w].valid && rd_row[w].tag == tag_q) begin
          f_hit = 1'b1; hw = WB'(w);
        end
        if (!rd_row[w].valid) begin
          f_inv = 1'b1; iw = WB'(w);
        end
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (w < int'(nways) && rd_row[w].rank > rd_row[vw].rank) vw = WB'(w);
    end
    way_c = f_hit ? hw : (f_inv ? iw : vw);
    wb_c = !f_hit && !f_inv && rd_row[vw].dirty;
    r_sel = rd_row[way_c].rank;
    wr_row = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row[w].rank < r_sel) wr_row[w].rank = rd_row[w].rank + 1'b1;
    end
    wr_row[way_c].rank = '0;
    if (f_hit) begin
      if (cmd_q == CMD_STORE) wr_row[way_c].dirty = 1'b1;
    end else begin
      wr_row[way_c].valid = 1'b1;
      wr_row[way_c].tag = tag_q;
      wr_row[way_c].dirty = cmd_q == CMD_STORE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLR) begin
      for (int w = 0; w < WAYS; w++) begin
        mem[clr_cnt[SB-1:0]][w] <= '{valid: 1'b0, dirty: 1'b0, tag: '0, rank: WB'(w)};
      end
    end else if (fin) begin
      mem[set_q] <= wr_row;
    end
    if (take) rd_row <= mem[set_c];
  end

  assign ev = '{hit: f_hit, miss: !f_hit, wb: wb_c, command: cmd_q};

  sactc_counters u_cnt (
    .clk(clk), .rst(rst), .bump(fin), .ev(ev), .counts(counts)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fin) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      hit <= f_hit;
      writeback <= wb_c;
      way_used <= 3'(way_c);
      set_used <= set_out;
    end
  end

  assign load_total = counts[0];
  assign load_miss_total = counts[1];
  assign store_total = counts[2];
  assign store_miss_total = counts[3];
  assign fetch_total = counts[4];
  assign fetch_miss_total = counts[5];
  assign writeback_total = counts[6];
endmodule
